// ----- hw/rtl/mandelbrot_escape_time_counter_macros.svh -----
// Assertion macros shared by the escape-time counter RTL.
// Expects a clock named clk and an active-high synchronous reset named rst.
`ifndef MANDELBROT_ESCAPE_TIME_COUNTER_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define METC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("metc assertion failed");

// Next-cycle implication, disabled during reset.
`define METC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("metc assertion failed");

`endif

// ----- hw/rtl/metc_pkg.sv -----
// Shared types and constants for the escape-time counter.
// No dependencies; used by the interfaces, controller, datapath and top level.
package metc_pkg;

  localparam int COORD_W     = 32;
  localparam int COUNT_W     = 12;
  localparam int THRESH_W    = 31;
  localparam int COLOR_W     = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_THRESHOLD = 1'd1;

  localparam logic [COUNT_W-1:0]  MAX_ITER_RESET  = 12'd2048;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 31'd1073741824;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UPD  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SQR  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic upd;
    logic mul;
    logic sqr;
    logic count_inc;
    logic set_esc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
    logic max_zero;
  } status_t;

endpackage

// ----- hw/rtl/metc_if.sv -----
// Valid/ready channel interfaces for points in and results out.
// Depends on metc_pkg for field widths.
interface metc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [metc_pkg::COORD_W-1:0] c_real;
  logic signed [metc_pkg::COORD_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface metc_out_if;
  logic                         valid;
  logic                         ready;
  logic [metc_pkg::COUNT_W-1:0] iteration_count;
  logic                         escaped;
  logic [metc_pkg::COLOR_W-1:0] gray_color;

  modport source (output valid, output iteration_count, output escaped,
                  output gray_color, input ready);
  modport sink (input valid, input iteration_count, input escaped,
                input gray_color, output ready);
endinterface

// ----- hw/rtl/metc_datapath.sv -----
// Datapath of the escape-time counter: z registers, three multipliers,
// saturation, escape compare, iteration count and output register. Uses metc_pkg.
module metc_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  metc_pkg::cmd_t                      cmd,
  input  logic signed [metc_pkg::COORD_W-1:0] c_real,
  input  logic signed [metc_pkg::COORD_W-1:0] c_imag,
  input  logic [metc_pkg::COUNT_W-1:0]        max_iterations,
  input  logic [metc_pkg::THRESH_W-1:0]       escape_threshold,
  output metc_pkg::status_t                   status,
  output logic [metc_pkg::COUNT_W-1:0]        iteration_count,
  output logic                                escaped,
  output logic [metc_pkg::COLOR_W-1:0]        gray_color
);
  import metc_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [COORD_W-1:0] r;
    if ((&v[65:31]) || !(|v[65:31])) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0]   cr;
  logic signed [COORD_W-1:0]   ci;
  logic signed [COORD_W-1:0]   x;
  logic signed [COORD_W-1:0]   y;
  logic signed [COORD_W-1:0]   x2;
  logic signed [COORD_W-1:0]   y2;
  logic signed [2*COORD_W-1:0] xy;
  logic signed [2*COORD_W-1:0] pxx;
  logic signed [2*COORD_W-1:0] pyy;
  logic signed [2*COORD_W-1:0] pxy;
  logic [COUNT_W-1:0]          count;
  logic                        esc;

  logic signed [2*COORD_W-1:0] fxx;
  logic signed [2*COORD_W-1:0] fyy;
  logic signed [COORD_W-1:0]   sq_x;
  logic signed [COORD_W-1:0]   sq_y;
  logic signed [33:0]          mag;
  logic signed [33:0]          thr_ext;
  logic signed [65:0]          ny_wide;
  logic signed [65:0]          nx_wide;
  logic [COUNT_W-1:0]          count_plus;

  assign fxx     = pxx >>> FRAC_BITS;
  assign fyy     = pyy >>> FRAC_BITS;
  assign sq_x    = sat32({{2{fxx[63]}}, fxx});
  assign sq_y    = sat32({{2{fyy[63]}}, fyy});
  assign mag     = {{2{sq_x[31]}}, sq_x} + {{2{sq_y[31]}}, sq_y};
  assign thr_ext = {3'b000, escape_threshold};

  assign ny_wide = {xy[63], xy, 1'b0} + {{34{ci[31]}}, ci};
  assign nx_wide = {{34{x2[31]}}, x2} - {{34{y2[31]}}, y2} + {{34{cr[31]}}, cr};

  assign count_plus = count + 12'd1;

  assign status.escape   = mag > thr_ext;
  assign status.last     = count_plus == max_iterations;
  assign status.max_zero = max_iterations == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= c_real;
      ci    <= c_imag;
      x2    <= '0;
      y2    <= '0;
      xy    <= '0;
      count <= '0;
      esc   <= 1'b0;
    end
    if (cmd.upd) begin
      x <= sat32(nx_wide);
      y <= sat32(ny_wide);
    end
    if (cmd.mul) begin
      pxx <= x * x;
      pyy <= y * y;
      pxy <= x * y;
    end
    if (cmd.sqr) begin
      x2 <= sq_x;
      y2 <= sq_y;
      xy <= pxy >>> FRAC_BITS;
    end
    if (cmd.count_inc) begin
      count <= count_plus;
    end
    if (cmd.set_esc) begin
      esc <= 1'b1;
    end
    if (cmd.out_load) begin
      iteration_count <= count;
      escaped         <= esc;
      gray_color      <= {3{count[7:0]}};
    end
  end

endmodule

// ----- hw/rtl/metc_controller.sv -----
// Sequencing state machine of the escape-time counter and the output valid flag.
// Uses metc_pkg for the state encoding and the command and status structs.
module metc_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  metc_pkg::status_t status,
  output metc_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid
);
  import metc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.max_zero ? ST_FIN : ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr = 1'b1;
        if (status.escape) begin
          cmd.set_esc = 1'b1;
          state_next  = ST_FIN;
        end else begin
          cmd.count_inc = 1'b1;
          state_next    = status.last ? ST_FIN : ST_UPD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/mandelbrot_escape_time_counter.sv -----
// Mandelbrot escape-time counter.
// A point c arrives as a transaction on in_ch (c_real, c_imag, signed fixed point
// with FRAC_BITS fraction bits). The block iterates z = z*z + c from z = 0 and
// sends one transaction on out_ch with the iteration count, the escaped flag and
// a gray color made of the count's low byte in all three color bytes.
// The configuration port writes max_iterations (index 0) and escape_threshold
// (index 1) on a cycle with cfg_we high; write it only while no point is in work.
// Each iteration steps through update z, multiply, and saturate and compare,
// all sharing one set of three 32x32 multipliers. When the maximum is 0 the point
// skips the iterations and goes straight to its result.
// One point is in work at a time; the next is accepted in the cycle after the
// result enters the output register, even if that result still waits.
// When out_ch stalls, a finished point waits in the controller until the output
// register frees. Reset returns the controller to idle, drops the output valid,
// and loads max_iterations = 2048 and escape_threshold = 4.0.
// Depends on metc_pkg, the channel interfaces, metc_controller and metc_datapath.
`include "mandelbrot_escape_time_counter_macros.svh"

module mandelbrot_escape_time_counter #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [metc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [metc_pkg::CFG_DATA_W-1:0]      cfg_data,
  metc_in_if.sink                              in_ch,
  metc_out_if.source                           out_ch
);
  import metc_pkg::*;

  logic [COUNT_W-1:0]  max_iterations;
  logic [THRESH_W-1:0] escape_threshold;
  cmd_t                cmd;
  status_t             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations   <= MAX_ITER_RESET;
      escape_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITERATIONS:   max_iterations   <= cfg_data[COUNT_W-1:0];
        CFG_ESCAPE_THRESHOLD: escape_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  metc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  metc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .c_real           (in_ch.c_real),
    .c_imag           (in_ch.c_imag),
    .max_iterations   (max_iterations),
    .escape_threshold (escape_threshold),
    .status           (status),
    .iteration_count  (out_ch.iteration_count),
    .escaped          (out_ch.escaped),
    .gray_color       (out_ch.gray_color)
  );

  `METC_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `METC_ASSERT_NOW(a_full_count_when_not_escaped, out_ch.valid && !out_ch.escaped,
                   out_ch.iteration_count == max_iterations)
  `METC_ASSERT_NOW(a_escape_below_max, out_ch.valid && out_ch.escaped,
                   out_ch.iteration_count < max_iterations)

endmodule

// ----- tb/tb_mandelbrot_escape_time_counter.sv -----
// Self-checking testbench for the Mandelbrot escape-time counter.
// Predicts count, escaped flag and gray color per point and compares each result transaction.
// Depends on metc_pkg, metc_in_if, metc_out_if and mandelbrot_escape_time_counter.
module tb_mandelbrot_escape_time_counter;
  import metc_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam longint S32_MAX = 64'sh7FFF_FFFF;
  localparam longint S32_MIN = -64'sh8000_0000;
  localparam logic signed [COORD_W-1:0] ONE = 32'sh1000_0000;
  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;

  typedef struct {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } point_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               esc;
    logic [COLOR_W-1:0] color;
  } escape_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  metc_in_if in_ch ();
  metc_out_if out_ch ();

  mandelbrot_escape_time_counter #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  logic [COUNT_W-1:0] iter_limit;
  logic [THRESH_W-1:0] threshold;

  point_t pending_points[$];
  escape_t awaited_results[$];
  point_t current_point;
  bit src_busy;
  bit in_took;
  bit out_took;
  bit steady;
  int gap_left;
  int stall_left;
  int hold_left;
  int hold_request;
  int mismatches;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic escape_t escape_time(logic signed [COORD_W-1:0] re,
                                          logic signed [COORD_W-1:0] im);
    longint cr, ci, x, y, x2, y2, nx;
    logic [COUNT_W-1:0] n;
    logic esc;
    int k;
    escape_t r;
    cr = re;
    ci = im;
    x = 0;
    y = 0;
    x2 = 0;
    y2 = 0;
    n = '0;
    esc = 1'b0;
    for (k = 0; k < iter_limit; k++) begin
      nx = clamp32(x2 - y2 + cr);
      y = clamp32(2 * fx_mul(x, y) + ci);
      x = nx;
      x2 = clamp32(fx_mul(x, x));
      y2 = clamp32(fx_mul(y, y));
      if (x2 + y2 > longint'({33'b0, threshold})) begin
        esc = 1'b1;
        break;
      end
      n++;
    end
    r.count = n;
    r.esc = esc;
    r.color = {n[7:0], n[7:0], n[7:0]};
    return r;
  endfunction

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk) begin
    escape_t want;
    if (rst) begin
      in_took = 1'b0;
      out_took = 1'b0;
    end else begin
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) begin
        awaited_results.push_back(escape_time(in_ch.c_real, in_ch.c_imag));
      end
      out_took = out_ch.valid && out_ch.ready;
      if (out_took) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transaction: count %0d escaped %0b color %06h",
                     out_ch.iteration_count, out_ch.escaped, out_ch.gray_color);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.iteration_count !== want.count || out_ch.escaped !== want.esc ||
              out_ch.gray_color !== want.color) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected count %0d escaped %0b color %06h, got %0d %0b %06h",
                       want.count, want.esc, want.color, out_ch.iteration_count,
                       out_ch.escaped, out_ch.gray_color);
            end
          end
        end
      end
    end
  end

  // Point driver.
  always @(negedge clk) begin
    if (rst) begin
      src_busy = 1'b0;
      gap_left = 0;
      in_ch.valid <= 1'b0;
    end else begin
      if (src_busy && in_took) src_busy = 1'b0;
      if (!src_busy && pending_points.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          current_point = pending_points.pop_front();
          src_busy = 1'b1;
          gap_left = steady ? 0 : $urandom_range(0, 10);
        end
      end
      in_ch.valid <= src_busy;
      if (src_busy) begin
        in_ch.c_real <= current_point.re;
        in_ch.c_imag <= current_point.im;
      end
    end
  end

  // Result receiver with per-transaction stalls and a single long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      hold_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_took) stall_left = steady ? 0 : $urandom_range(0, 10);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_point(logic signed [COORD_W-1:0] re, logic signed [COORD_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    pending_points.push_back(p);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ITERATIONS) begin
      iter_limit = value[COUNT_W-1:0];
    end else begin
      threshold = value[THRESH_W-1:0];
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_points.size() != 0 || src_busy || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase;
    int i;
    logic [CFG_DATA_W-1:0] value;
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.c_real = '0;
    in_ch.c_imag = '0;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    hold_request = 0;
    mismatches = 0;
    iter_limit = MAX_ITER_RESET;
    threshold = THRESHOLD_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: points inside, on the boundary and at the extremes.
    @(posedge clk);
    add_point(0, 0);
    add_point(-2 * ONE, 0);
    add_point(-ONE, 0);
    add_point(ONE / 4, 0);
    add_point(0, ONE);
    add_point(CMIN, CMIN);
    add_point(CMAX, CMAX);
    add_point(CMIN, CMAX);
    add_point(CMAX, CMIN);
    add_point(1, -1);
    wait_drained();

    // Largest maximum and threshold; the maximum's written data carries bits above its field.
    write_reg(CFG_MAX_ITERATIONS, 31'h7FFF_FFFF);
    write_reg(CFG_ESCAPE_THRESHOLD, 31'h7FFF_FFFF);
    @(posedge clk);
    add_point(0, 0);
    add_point(CMIN, 0);
    add_point(2 * ONE, 0);
    add_point(CMAX, CMAX);
    wait_drained();

    // Zero maximum performs no iteration.
    write_reg(CFG_MAX_ITERATIONS, 31'h4000_0000);
    @(posedge clk);
    add_point(0, 0);
    add_point(CMAX, CMIN);
    add_point(-ONE, ONE / 2);
    wait_drained();

    // Zero threshold with a single iteration.
    write_reg(CFG_MAX_ITERATIONS, 31'd1);
    write_reg(CFG_ESCAPE_THRESHOLD, 31'd0);
    @(posedge clk);
    add_point(0, 0);
    add_point(1, 0);
    add_point(32'sd16384, 0);
    add_point(-1, -1);
    wait_drained();

    // Floor rounding of tiny negative products.
    write_reg(CFG_MAX_ITERATIONS, 31'd2);
    write_reg(CFG_ESCAPE_THRESHOLD, 31'd1);
    @(posedge clk);
    add_point(-1, 1);
    add_point(-32'sd16384, 32'sd16384);
    add_point(32'sd8191, -32'sd8193);
    wait_drained();

    for (phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 5))
        0: value = {19'($urandom_range(0, 32'h7FFFF)), 12'd0};
        1: value = {19'($urandom_range(0, 32'h7FFFF)), 12'($urandom_range(100, 200))};
        default: value = {19'($urandom_range(0, 32'h7FFFF)), 12'($urandom_range(1, 48))};
      endcase
      write_reg(CFG_MAX_ITERATIONS, value);
      case ($urandom_range(0, 4))
        0: value = 31'(THRESHOLD_RESET);
        1: value = 31'($urandom);
        2: value = 31'($urandom_range(0, 32'h10_0000));
        3: value = 31'h7FFF_FFFF;
        default: value = 31'($urandom_range(32'h0800_0000, 32'h2000_0000));
      endcase
      write_reg(CFG_ESCAPE_THRESHOLD, value);
      @(posedge clk);
      steady = (phase % 3 == 1);
      if (phase == 4) hold_request = 300;
      for (i = 0; i < 30; i++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            re = $urandom;
            im = $urandom;
          end
          2, 3: begin
            re = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            im = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
          end
          default: begin
            re = $signed($urandom_range(0, 32'd671088640)) - 32'sd536870912;
            im = $signed($urandom_range(0, 32'd671088640)) - 32'sd335544320;
          end
        endcase
        add_point(re, im);
      end
      wait_drained();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
